// ===== rtl/core/ps2smp_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2smp_pkg
// Shared types and constants for the PS/2 to serial mouse packet unit.
// ----------------------------------------------------------------------------
package ps2smp_pkg;

    localparam int SER_W      = 7;
    localparam int JOB_BYTES  = 4;
    localparam int JOB_IDX_W  = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW   = 1;
    localparam int QUEUE_CW   = 2;

    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_DISCARD = 1'b1;

    localparam logic MODE_WHEEL  = 1'b0;
    localparam logic MODE_3BTN   = 1'b1;

    localparam logic [1:0] CNT_HDR   = 2'd0;
    localparam logic [1:0] CNT_X     = 2'd1;
    localparam logic [1:0] CNT_Y     = 2'd2;
    localparam logic [1:0] CNT_WHEEL = 2'd3;

    localparam logic [7:0] SPACE_3BTN  = 8'd3;
    localparam logic [7:0] SPACE_WHEEL = 8'd4;

    typedef struct packed {
        logic [JOB_BYTES-1:0][SER_W-1:0] bytes;
        logic [JOB_IDX_W-1:0]            last_idx;
    } job_t;

    // clamp a 9-bit two's complement value (sign bit and low byte) to 8 bits
    function automatic logic [7:0] clamp8(input logic neg, input logic [7:0] v);
        logic [7:0] r;
        if (neg)
            r = v[7] ? v : 8'h80;
        else
            r = v[7] ? 8'h7F : v;
        return r;
    endfunction

endpackage

// ===== rtl/core/ps2smp_front.sv =====
// ----------------------------------------------------------------------------
// ps2smp_front
// Accepts PS/2 bytes, tracks packet assembly and builds serial byte jobs.
// ----------------------------------------------------------------------------
module ps2smp_front
    import ps2smp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       packet_mode,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       action,
    input  logic [7:0] ps2_byte,
    input  logic [7:0] tx_space,
    input  logic       q_full,
    output logic       push,
    output job_t       push_job
);

    logic [1:0] byte_count_reg, byte_count_next;
    logic       dropped_reg, dropped_next;
    logic       mws_reg, mws_next;
    logic [7:0] hdr_reg, hdr_next;
    logic [7:0] xb_reg, xb_next;

    logic       accept;
    logic [7:0] xm, ym_c, ym;
    logic [6:0] b1;
    logic       fourth;
    logic       wneg;
    logic [3:0] wnib;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign xm     = clamp8(hdr_reg[4], xb_reg);
    assign ym_c   = clamp8(hdr_reg[5], ps2_byte);
    assign ym     = 8'd0 - ym_c;
    assign b1     = {1'b1, hdr_reg[0], hdr_reg[1], ym[7:6], xm[7:6]};
    assign fourth = hdr_reg[2] || mws_reg;

    assign wneg = (ps2_byte[7:4] != 4'd0);
    always_comb
    begin
        if (wneg)
            wnib = ps2_byte[3] ? ps2_byte[3:0] : 4'h8;
        else
            wnib = ps2_byte[3] ? 4'h7 : ps2_byte[3:0];
    end

    always_comb
    begin
        byte_count_next = byte_count_reg;
        dropped_next    = dropped_reg;
        mws_next        = mws_reg;
        hdr_next        = hdr_reg;
        xb_next         = xb_reg;
        push            = 1'b0;
        push_job        = '0;
        if (accept) begin
            if (action == ACT_DISCARD) begin
                byte_count_next = CNT_HDR;
            end else begin
                unique case (byte_count_reg)
                    CNT_HDR:
                    begin
                        hdr_next        = ps2_byte;
                        byte_count_next = CNT_X;
                    end
                    CNT_X:
                    begin
                        xb_next         = ps2_byte;
                        byte_count_next = CNT_Y;
                    end
                    CNT_Y:
                    begin
                        push_job.bytes[0] = b1;
                        push_job.bytes[1] = {1'b0, xm[5:0]};
                        push_job.bytes[2] = {1'b0, ym[5:0]};
                        push_job.bytes[3] = {1'b0, hdr_reg[2], 5'd0};
                        push_job.last_idx = JOB_IDX_W'(2);
                        if (packet_mode == MODE_3BTN) begin
                            byte_count_next = CNT_HDR;
                            if (tx_space >= SPACE_3BTN) begin
                                push = 1'b1;
                                if (fourth) begin
                                    push_job.last_idx = JOB_IDX_W'(3);
                                    mws_next          = hdr_reg[2];
                                end
                            end
                        end else begin
                            byte_count_next = CNT_WHEEL;
                            if (tx_space < SPACE_WHEEL) begin
                                dropped_next = 1'b1;
                            end else begin
                                dropped_next = 1'b0;
                                push         = 1'b1;
                            end
                        end
                    end
                    CNT_WHEEL:
                    begin
                        byte_count_next   = CNT_HDR;
                        push_job.bytes[0] = {2'b00, hdr_reg[2], wnib};
                        push_job.last_idx = JOB_IDX_W'(0);
                        push              = !dropped_reg;
                    end
                    default:
                    begin
                        byte_count_next = CNT_HDR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_count_reg <= CNT_HDR;
            dropped_reg    <= 1'b0;
            mws_reg        <= 1'b0;
        end else begin
            byte_count_reg <= byte_count_next;
            dropped_reg    <= dropped_next;
            mws_reg        <= mws_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
        xb_reg  <= xb_next;
    end

endmodule

// ===== rtl/core/ps2smp_queue.sv =====
// ----------------------------------------------------------------------------
// ps2smp_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module ps2smp_queue
    import ps2smp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output job_t head
);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full      = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(do_push);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(do_pop);
        count_next  = count_reg + QUEUE_CW'(do_push) - QUEUE_CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== rtl/core/ps2smp_back.sv =====
// ----------------------------------------------------------------------------
// ps2smp_back
// Takes jobs from the queue and streams their bytes through an output register.
// ----------------------------------------------------------------------------
module ps2smp_back
    import ps2smp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_not_empty,
    input  job_t             q_head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [SER_W-1:0] serial_byte,
    output logic             last
);

    job_t                 job_reg, job_next;
    logic                 job_valid_reg, job_valid_next;
    logic [JOB_IDX_W-1:0] idx_reg, idx_next;
    logic                 ov_reg, ov_next;
    logic [SER_W-1:0]     sb_reg, sb_next;
    logic                 last_reg, last_next;
    logic                 advance, job_done;

    assign advance  = job_valid_reg && (!ov_reg || out_ready);
    assign job_done = advance && (idx_reg == job_reg.last_idx);
    assign pop      = q_not_empty && (!job_valid_reg || job_done);

    always_comb
    begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        ov_next        = ov_reg;
        sb_next        = sb_reg;
        last_next      = last_reg;
        if (out_ready)
            ov_next = 1'b0;
        if (advance) begin
            ov_next   = 1'b1;
            sb_next   = job_reg.bytes[idx_reg];
            last_next = (idx_reg == job_reg.last_idx);
            idx_next  = idx_reg + JOB_IDX_W'(1);
        end
        if (job_done)
            job_valid_next = 1'b0;
        if (pop) begin
            job_next       = q_head;
            job_valid_next = 1'b1;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            ov_reg        <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        sb_reg   <= sb_next;
        last_reg <= last_next;
    end

    assign out_valid   = ov_reg;
    assign serial_byte = sb_reg;
    assign last        = last_reg;

endmodule

// ===== rtl/core/ps2_to_serial_mouse_packet_unit.sv =====
// ----------------------------------------------------------------------------
// ps2_to_serial_mouse_packet_unit
// PS/2 mouse packet bytes in, Microsoft serial mouse bytes out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one PS/2 byte or a discard action per
// transaction, with the current free space of the serial buffer.
// Output channel (out_valid/out_ready): one 7-bit serial byte per transaction,
// last marks the final byte produced for an input transaction.
// cfg_wr_en/cfg_wr_data write packet_mode (0 wheel, 1 three-button); write
// only while idle.
// An input's bytes pass through the job queue, the job register and the output
// register. Throughput: one output byte per cycle while out_ready stays high;
// inputs are taken every cycle while the 2-entry job queue has room.
// Reset clears the packet position, drop and middle-button flags and the
// mode (wheel). When out_ready is low the output byte holds, the queue
// fills, and in_ready drops once it is full.
// ----------------------------------------------------------------------------
module ps2_to_serial_mouse_packet_unit
    import ps2smp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             action,
    input  logic [7:0]       ps2_byte,
    input  logic [7:0]       tx_space,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [SER_W-1:0] serial_byte,
    output logic             last
);

    logic packet_mode_reg;
    logic q_full, q_not_empty, push, pop;
    job_t push_job, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            packet_mode_reg <= MODE_WHEEL;
        else if (cfg_wr_en)
            packet_mode_reg <= cfg_wr_data;
    end

    ps2smp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .packet_mode (packet_mode_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .ps2_byte    (ps2_byte),
        .tx_space    (tx_space),
        .q_full      (q_full),
        .push        (push),
        .push_job    (push_job)
    );

    ps2smp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    ps2smp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .serial_byte (serial_byte),
        .last        (last)
    );

endmodule

// ===== rtl/core/ps2smp_checker.sv =====
// ----------------------------------------------------------------------------
// ps2smp_checker
// Port-level checks for the PS/2 to serial mouse packet unit.
// ----------------------------------------------------------------------------
module ps2smp_checker
    import ps2smp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [SER_W-1:0] serial_byte,
    input logic             last
);

    // stalled output holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(serial_byte) && $stable(last))
        else $error("output changed while stalled");

    // header byte never ends a transaction group
    a_hdr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && serial_byte[6] |-> !last)
        else $error("header byte flagged last");

    // header is followed by X byte, never another header
    a_hdr_then_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && serial_byte[6] |=> !(out_valid && serial_byte[6]))
        else $error("two header bytes in a row");

    // bytes of one group stream without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("gap inside byte group");

endmodule

bind ps2_to_serial_mouse_packet_unit ps2smp_checker u_ps2smp_checker (.*);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ps2_to_serial_mouse_packet_unit. A short directed
// table covers the field extremes, both packet modes, the drop on a short
// output buffer, the discard action, the middle-button release byte and a mode
// change in the middle of a packet. Random packets, broken packets and noise
// follow over several idle/stall phases. Every output byte is compared with
// the bytes typed in the table or given by an in-bench model of the converter.
// ----------------------------------------------------------------------------
module testbench;
    import ps2smp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 8;
    localparam int ITEMS_PER_PHASE = 18;

    typedef struct packed {
        logic [6:0] sbyte;
        logic       fin;
    } serial_rec_t;

    typedef struct packed {
        logic            is_cfg;
        logic            act;
        logic [7:0]      b;
        logic [7:0]      s;
        int              n_typed;
        logic [3:0][6:0] e;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       action = ACT_BYTE;
    logic [7:0] ps2_byte = 8'h00;
    logic [7:0] tx_space = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [6:0] serial_byte;
    logic       last;

    // converter model state
    logic       mode_now = MODE_WHEEL;
    logic [1:0] pos_now = CNT_HDR;
    logic [7:0] pkt_now [3];
    logic       drop_pending = 1'b0;
    logic       mid_shown = 1'b0;

    serial_rec_t serial_due[$];
    stim_row_t   plan[$];
    int          bad_bytes = 0;
    int          tx_gap_pct = 0;
    int          rx_stall_pct = 0;

    ps2_to_serial_mouse_packet_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .ps2_byte    (ps2_byte),
        .tx_space    (tx_space),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .serial_byte (serial_byte),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] to_twos(input logic neg, input logic [7:0] mag);
        if (neg)
            return (mag >= 8'h80) ? mag : 8'h80;
        return (mag > 8'h7F) ? 8'h7F : mag;
    endfunction

    // advances the model by one transaction, returns the number of serial bytes
    function automatic int mouse_bytes(input logic act, input logic [7:0] b,
                                       input logic [7:0] s,
                                       output logic [3:0][6:0] sb);
        logic [7:0] xm;
        logic [7:0] ym;
        logic [7:0] w;
        sb = '0;
        if (act == ACT_DISCARD)
        begin
            pos_now = CNT_HDR;
            return 0;
        end
        if (pos_now != CNT_WHEEL)
        begin
            pkt_now[pos_now] = b;
            pos_now = pos_now + 2'd1;
            if (pos_now != CNT_WHEEL)
                return 0;
            if (mode_now == MODE_3BTN)
            begin
                pos_now = CNT_HDR;
                if (s < SPACE_3BTN)
                    return 0;
            end
            else if (s < SPACE_WHEEL)
            begin
                drop_pending = 1'b1;
                return 0;
            end
            else
                drop_pending = 1'b0;
            xm = to_twos(pkt_now[0][4], pkt_now[1]);
            ym = 8'h00 - to_twos(pkt_now[0][5], pkt_now[2]);
            sb[0] = {1'b1, pkt_now[0][0], pkt_now[0][1], ym[7:6], xm[7:6]};
            sb[1] = {1'b0, xm[5:0]};
            sb[2] = {1'b0, ym[5:0]};
            if (mode_now == MODE_3BTN && (pkt_now[0][2] || mid_shown))
            begin
                sb[3] = {1'b0, pkt_now[0][2], 5'b0};
                mid_shown = pkt_now[0][2];
                return 4;
            end
            return 3;
        end
        pos_now = CNT_HDR;
        if (drop_pending)
            return 0;
        w = to_twos(b[7:4] != 4'h0, {b[3:0], 4'h0});
        sb[0] = {2'b00, pkt_now[0][2], w[7:4]};
        return 1;
    endfunction

    function automatic stim_row_t row(input logic act, input logic [7:0] b,
                                      input logic [7:0] s, input int n,
                                      input logic [6:0] e0 = '0, input logic [6:0] e1 = '0,
                                      input logic [6:0] e2 = '0, input logic [6:0] e3 = '0);
        stim_row_t r;
        r.is_cfg = 1'b0;
        r.act = act;
        r.b = b;
        r.s = s;
        r.n_typed = n;
        r.e = {e3, e2, e1, e0};
        return r;
    endfunction

    function automatic stim_row_t mode_row(input logic m);
        stim_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.b[0] = m;
        return r;
    endfunction

    task automatic ship(input logic act, input logic [7:0] b, input logic [7:0] s,
                        input int n_typed, input logic [3:0][6:0] typed_b);
        logic [3:0][6:0] got;
        int n;
        action <= act;
        ps2_byte <= b;
        tx_space <= s;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        n = mouse_bytes(act, b, s, got);
        if (n_typed >= 0)
        begin
            n = n_typed;
            got = typed_b;
        end
        for (int k = 0; k < n; k++)
            serial_due.push_back(serial_rec_t'{got[k], k == n - 1});
        if ($urandom_range(99) < tx_gap_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_gap_pct);
        end
    endtask

    // mode is only changed once the unit has gone quiet
    task automatic set_mode(input logic m);
        in_valid <= 1'b0;
        while (serial_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        mode_now = m;
    endtask

    always @(posedge clk)
    begin
        serial_rec_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (serial_due.size() == 0)
            begin
                $error("serial_byte 0x%02h with no transaction pending", serial_byte);
                bad_bytes++;
            end
            else
            begin
                want = serial_due.pop_front();
                if (serial_byte !== want.sbyte)
                begin
                    $error("serial_byte expected 0x%02h actual 0x%02h",
                           want.sbyte, serial_byte);
                    bad_bytes++;
                end
                if (last !== want.fin)
                begin
                    $error("last expected %0b actual %0b", want.fin, last);
                    bad_bytes++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        stim_row_t  r;
        int         byte_items;
        int         len;
        int         cut;
        int         pick;
        logic [7:0] b;
        logic [7:0] s;

        // wheel mode after reset
        plan.push_back(row(ACT_BYTE, 8'h08, 8'd4, 0));
        plan.push_back(row(ACT_BYTE, 8'h00, 8'd4, 0));
        plan.push_back(row(ACT_BYTE, 8'h00, 8'd4, 3, 7'h40, 7'h00, 7'h00));
        plan.push_back(row(ACT_BYTE, 8'h00, 8'd4, 1, 7'h00));
        // all buttons, both signs, zero magnitude: clamp to -128
        plan.push_back(row(ACT_BYTE, 8'h3F, 8'd255, 0));
        plan.push_back(row(ACT_BYTE, 8'h00, 8'd255, 0));
        plan.push_back(row(ACT_BYTE, 8'h00, 8'd255, 3, 7'h7A, 7'h00, 7'h00));
        plan.push_back(row(ACT_BYTE, 8'hFF, 8'd255, 1, 7'h1F));
        // positive overflow clamps to +127, overflow bits ignored
        plan.push_back(row(ACT_BYTE, 8'hC8, 8'd4, 0));
        plan.push_back(row(ACT_BYTE, 8'hFF, 8'd4, 0));
        plan.push_back(row(ACT_BYTE, 8'hFF, 8'd4, 3, 7'h49, 7'h3F, 7'h01));
        plan.push_back(row(ACT_BYTE, 8'h80, 8'd4, 1, 7'h08));
        // discard after header, then a packet dropped for lack of space
        plan.push_back(row(ACT_BYTE, 8'h0B, 8'd9, 0));
        plan.push_back(row(ACT_DISCARD, 8'hA5, 8'd9, 0));
        plan.push_back(row(ACT_BYTE, 8'h0B, 8'd9, 0));
        plan.push_back(row(ACT_BYTE, 8'h41, 8'd9, 0));
        plan.push_back(row(ACT_BYTE, 8'h9C, 8'd3, 0));
        plan.push_back(row(ACT_BYTE, 8'h07, 8'd200, 0));
        // switch to three-button mode while the wheel byte is still due
        plan.push_back(row(ACT_BYTE, 8'h09, 8'd4, -1));
        plan.push_back(row(ACT_BYTE, 8'h02, 8'd4, -1));
        plan.push_back(row(ACT_BYTE, 8'h03, 8'd4, -1));
        plan.push_back(mode_row(MODE_3BTN));
        plan.push_back(row(ACT_BYTE, 8'hF8, 8'd4, -1));
        // middle press, release, and a short buffer
        plan.push_back(row(ACT_BYTE, 8'h0C, 8'd3, -1));
        plan.push_back(row(ACT_BYTE, 8'h10, 8'd3, -1));
        plan.push_back(row(ACT_BYTE, 8'hF0, 8'd3, -1));
        plan.push_back(row(ACT_BYTE, 8'h08, 8'd3, 0));
        plan.push_back(row(ACT_BYTE, 8'h00, 8'd3, 0));
        plan.push_back(row(ACT_BYTE, 8'h00, 8'd3, 4, 7'h40, 7'h00, 7'h00, 7'h00));
        plan.push_back(row(ACT_BYTE, 8'h0C, 8'd0, 0));
        plan.push_back(row(ACT_BYTE, 8'h00, 8'd0, 0));
        plan.push_back(row(ACT_BYTE, 8'h00, 8'd0, 0));

        for (int k = 0; k < 3; k++)
            pkt_now[k] = 8'h00;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            r = plan[i];
            if (r.is_cfg)
                set_mode(r.b[0]);
            else
                ship(r.act, r.b, r.s, r.n_typed, r.e);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            set_mode(phase[0] ? MODE_3BTN : MODE_WHEEL);
            tx_gap_pct = (phase == 1) ? 56 : (phase == 3) ? 18 : 0;
            rx_stall_pct = (phase == 2) ? 56 : (phase == 3) ? 18 : 0;
            byte_items = 0;
            while (byte_items < ITEMS_PER_PHASE)
            begin
                len = (mode_now == MODE_WHEEL) ? 4 : 3;
                pick = $urandom_range(99);
                if (pick < 8)
                begin
                    ship(ACT_DISCARD, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         -1, '0);
                    continue;
                end
                cut = (pick < 18) ? $urandom_range(1, len - 1) : len;
                for (int j = 0; j < cut; j++)
                begin
                    if (j == 3 && $urandom_range(1))
                        b = {{4{1'($urandom_range(1))}}, 4'($urandom_range(15))};
                    else
                        b = 8'($urandom_range(255));
                    s = ($urandom_range(3) == 0) ? 8'($urandom_range(4))
                                                 : 8'($urandom_range(4, 255));
                    ship(ACT_BYTE, b, s, -1, '0);
                    byte_items++;
                end
                if (cut < len)
                    ship(ACT_DISCARD, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         -1, '0);
            end
        end

        in_valid <= 1'b0;
        while (serial_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES + 4) @(posedge clk);
        if (bad_bytes == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ps2smp_pkg.sv
rtl/core/ps2smp_front.sv
rtl/core/ps2smp_queue.sv
rtl/core/ps2smp_back.sv
rtl/core/ps2_to_serial_mouse_packet_unit.sv
rtl/core/ps2smp_checker.sv
dv/testbench.sv
